[sv/imc_pkg.sv]
// Package for the instruction mix counter: class codes, op codes and opcode constants.
package imc_pkg;

  // Number of instruction classes and counter width
  localparam int unsigned NUM_CLASSES = 11;
  localparam int unsigned CNT_W       = 32;

  typedef logic [3:0]       class_t;
  typedef logic [1:0]       op_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [5:0]       opc_t;

  // Operation codes
  localparam op_t OP_COUNT = 2'd0;
  localparam op_t OP_CLEAR = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  // Class codes
  localparam class_t CLS_ADD    = 4'd0;
  localparam class_t CLS_SUB    = 4'd1;
  localparam class_t CLS_MUL    = 4'd2;
  localparam class_t CLS_DIV    = 4'd3;
  localparam class_t CLS_LOGIC  = 4'd4;
  localparam class_t CLS_RELAT  = 4'd5;
  localparam class_t CLS_SHIFT  = 4'd6;
  localparam class_t CLS_LOAD   = 4'd7;
  localparam class_t CLS_STORE  = 4'd8;
  localparam class_t CLS_BRANCH = 4'd9;
  localparam class_t CLS_OTHER  = 4'd10;

  // Primary opcodes with special meaning
  localparam opc_t OPC_RTYPE = 6'h3A;
  localparam opc_t OPC_JTYPE = 6'h00;

endpackage

[sv/imc_classify.sv]
// Instruction word decoder: sorts one word into its instruction class.
module imc_classify
  import imc_pkg::*;
(
  input  logic [31:0] instr_word,
  output class_t      cls
);

  opc_t prim;
  opc_t ext;
  class_t r_cls;
  class_t i_cls;

  assign prim = instr_word[5:0];
  assign ext  = instr_word[16:11];

  // R-type extended opcode decode
  always_comb begin
    unique case (ext)
      6'h08, 6'h10, 6'h18, 6'h20, 6'h28, 6'h30: r_cls = CLS_RELAT;
      6'h06, 6'h0E, 6'h16, 6'h1E:               r_cls = CLS_LOGIC;
      6'h31:                                    r_cls = CLS_ADD;
      6'h39:                                    r_cls = CLS_SUB;
      6'h07, 6'h17, 6'h1F, 6'h27:               r_cls = CLS_MUL;
      6'h24, 6'h25:                             r_cls = CLS_DIV;
      6'h0D:                                    r_cls = CLS_BRANCH;
      6'h02, 6'h03, 6'h0B, 6'h12, 6'h13,
      6'h1A, 6'h1B, 6'h3A, 6'h3B:               r_cls = CLS_SHIFT;
      default:                                  r_cls = CLS_OTHER;
    endcase
  end

  // I-type primary opcode decode
  always_comb begin
    unique case (prim)
      6'h08, 6'h10, 6'h18, 6'h20, 6'h28, 6'h30: i_cls = CLS_RELAT;
      6'h0C, 6'h14, 6'h1C, 6'h2C, 6'h34, 6'h3C: i_cls = CLS_LOGIC;
      6'h04:                                    i_cls = CLS_ADD;
      6'h24:                                    i_cls = CLS_MUL;
      6'h06, 6'h0E, 6'h16, 6'h1E, 6'h26, 6'h2E,
      6'h36:                                    i_cls = CLS_BRANCH;
      6'h03, 6'h23, 6'h07, 6'h27, 6'h0B, 6'h2B,
      6'h0F, 6'h2F, 6'h17, 6'h37:               i_cls = CLS_LOAD;
      6'h05, 6'h25, 6'h0D, 6'h2D, 6'h15, 6'h35: i_cls = CLS_STORE;
      default:                                  i_cls = CLS_OTHER;
    endcase
  end

  // R-type first, J-type counts as other
  always_comb begin
    priority if (prim == OPC_RTYPE) begin
      cls = r_cls;
    end else if (prim == OPC_JTYPE) begin
      cls = CLS_OTHER;
    end else begin
      cls = i_cls;
    end
  end

endmodule

[sv/instruction_mix_counter_core.sv]
// Instruction mix counter: input register, class decode, counter update, result register.
// A transaction is captured in the input register, then in the result register that drives the output.
// Throughput: one transaction per cycle when not stalled; the counter read-modify-write sits in one stage.
// Output stall holds the result and a full input stage; the input stalls only when both are full and held.
// Reset (rst, synchronous) clears all eleven counters and both stage valids.
module instruction_mix_counter_core
  import imc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] instr_word,
  input  logic [3:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  category,
  output logic [31:0] count_value
);

  // Input stage registers
  logic        s1_valid;
  op_t         s1_op;
  logic [31:0] s1_word;
  class_t      s1_idx;

  // Counter bank
  count_t counts [NUM_CLASSES];

  logic   advance;
  logic   fire;
  class_t cls;
  class_t rd_addr;
  count_t rd_data;
  count_t cnt_inc;
  class_t cat_next;
  count_t val_next;

  // Pipeline flow control
  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_op   <= op;
      s1_word <= instr_word;
      s1_idx  <= read_index;
    end
  end

  imc_classify u_classify (
    .instr_word (s1_word),
    .cls        (cls)
  );

  // Counter read port, shared by count and read
  assign rd_addr = (s1_op == OP_COUNT) ? cls : s1_idx;
  assign rd_data = (rd_addr < class_t'(NUM_CLASSES)) ? counts[rd_addr] : '0;
  assign cnt_inc = rd_data + count_t'(1);

  // Result select
  always_comb begin
    unique case (s1_op)
      OP_COUNT: begin
        cat_next = cls;
        val_next = cnt_inc;
      end
      OP_READ: begin
        cat_next = s1_idx;
        val_next = rd_data;
      end
      default: begin
        cat_next = '0;
        val_next = '0;
      end
    endcase
  end

  // Counter update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) counts[i] <= '0;
    end else if (fire) begin
      if (s1_op == OP_CLEAR) begin
        for (int i = 0; i < NUM_CLASSES; i++) counts[i] <= '0;
      end else if (s1_op == OP_COUNT) begin
        counts[cls] <= cnt_inc;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      category    <= cat_next;
      count_value <= val_next;
    end
  end

`ifndef SYNTHESIS
  // Input side stalls only behind a full input stage
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input stage");

  // Count transaction returns the incremented counter
  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_op == OP_COUNT) |=> (out_valid && count_value == $past(cnt_inc)))
    else $error("count result does not match incremented counter");

  // Clear leaves the counters at zero
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_op == OP_CLEAR) |=>
      (counts[CLS_ADD] == '0 && counts[CLS_OTHER] == '0 && count_value == '0))
    else $error("counters not cleared");

  // Written counter matches the reported value
  a_count_wr: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_op == OP_COUNT) |=> (counts[category] == count_value))
    else $error("counter bank and result disagree");
`endif

endmodule

[tb/imc_checker.sv]
// Checker for the instruction mix counter: predicts every transaction and compares results.
`timescale 1ns / 100ps
module imc_checker
  import imc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] instr_word,
  input  logic [3:0]  read_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  category,
  input  logic [31:0] count_value,
  output int          mismatches,
  output int          awaited,
  output int          compared
);

  typedef struct packed {
    class_t cat;
    count_t val;
  } mix_result_t;

  // Model copy of the per-class counters and the results still in flight
  count_t      class_tally [NUM_CLASSES];
  mix_result_t mix_results_q [$];

  // Extended opcode decode for R-type words
  function automatic class_t rtype_class(opc_t x);
    case (x)
      6'h08, 6'h10, 6'h18, 6'h20, 6'h28, 6'h30: return CLS_RELAT;
      6'h06, 6'h0E, 6'h16, 6'h1E:               return CLS_LOGIC;
      6'h31:                                    return CLS_ADD;
      6'h39:                                    return CLS_SUB;
      6'h07, 6'h17, 6'h1F, 6'h27:               return CLS_MUL;
      6'h24, 6'h25:                             return CLS_DIV;
      6'h0D:                                    return CLS_BRANCH;
      6'h02, 6'h03, 6'h0B, 6'h12, 6'h13,
      6'h1A, 6'h1B, 6'h3A, 6'h3B:               return CLS_SHIFT;
      default:                                  return CLS_OTHER;
    endcase
  endfunction

  // Primary opcode decode for I-type words
  function automatic class_t itype_class(opc_t p);
    case (p)
      6'h08, 6'h10, 6'h18, 6'h20, 6'h28, 6'h30:        return CLS_RELAT;
      6'h0C, 6'h14, 6'h1C, 6'h2C, 6'h34, 6'h3C:        return CLS_LOGIC;
      6'h04:                                           return CLS_ADD;
      6'h24:                                           return CLS_MUL;
      6'h06, 6'h0E, 6'h16, 6'h1E, 6'h26, 6'h2E, 6'h36: return CLS_BRANCH;
      6'h03, 6'h23, 6'h07, 6'h27, 6'h0B, 6'h2B,
      6'h0F, 6'h2F, 6'h17, 6'h37:                      return CLS_LOAD;
      6'h05, 6'h25, 6'h0D, 6'h2D, 6'h15, 6'h35:        return CLS_STORE;
      default:                                         return CLS_OTHER;
    endcase
  endfunction

  function automatic class_t word_class(logic [31:0] w);
    if (w[5:0] == OPC_RTYPE) return rtype_class(w[16:11]);
    if (w[5:0] == OPC_JTYPE) return CLS_OTHER;
    return itype_class(w[5:0]);
  endfunction

  // Apply one transaction to the model counters and return the expected result
  function automatic mix_result_t tally_update(logic [1:0] o, logic [31:0] w, logic [3:0] idx);
    mix_result_t r;
    class_t      c;
    r = '0;
    case (o)
      OP_COUNT: begin
        c = word_class(w);
        class_tally[c] = class_tally[c] + 1'b1;
        r.cat = c;
        r.val = class_tally[c];
      end
      OP_CLEAR: begin
        foreach (class_tally[i]) class_tally[i] = '0;
      end
      OP_READ: begin
        r.cat = idx;
        if (idx < NUM_CLASSES) r.val = class_tally[idx];
      end
      default: ;  // unused op: no change, zero result
    endcase
    return r;
  endfunction

  initial begin
    mismatches = 0;
    awaited    = 0;
    compared   = 0;
    foreach (class_tally[i]) class_tally[i] = '0;
  end

  // Queue on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    mix_result_t want;
    if (rst) begin
      mix_results_q.delete();
      foreach (class_tally[i]) class_tally[i] = '0;
    end else begin
      if (in_valid && !in_stall)
        mix_results_q.push_back(tally_update(op, instr_word, read_index));
      if (out_valid && !out_stall) begin
        compared++;
        if (mix_results_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing expected: category=%0d count_value=%0d",
                     $realtime, category, count_value);
          mismatches++;
        end else begin
          want = mix_results_q.pop_front();
          if (category !== want.cat || count_value !== want.val) begin
            if (mismatches < 10)
              $display("%0t: mismatch: category exp %0d got %0d, count_value exp %0d got %0d",
                       $realtime, want.cat, category, want.val, count_value);
            mismatches++;
          end
        end
      end
    end
    awaited = mix_results_q.size();
  end

endmodule

[tb/tb_instruction_mix_counter_core.sv]
// Testbench top for the instruction mix counter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_instruction_mix_counter_core
  import imc_pkg::*;
();

  // Op code 3 has no meaning in the block; it must still return a zero result
  localparam op_t OP_NONE    = 2'd3;
  localparam int  IDLE_LIMIT = 2000;
  localparam int  HOLD_LEN   = 48;
  localparam int  CHUNKS     = 13;
  localparam int  CHUNK_LEN  = 50;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op;
  logic [31:0] instr_word;
  logic [3:0]  read_index;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  category;
  logic [31:0] count_value;

  int mismatches;
  int awaited;
  int compared;
  int idle_cycles;
  int n_count, n_clear, n_read, n_none;
  bit calm;
  bit hold_req;

  instruction_mix_counter_core dut (.*);
  imc_checker chk (.*);

  // Clock: 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: ends the run when nothing moves for too long
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_instruction_mix_counter_core failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Word with the given primary and extended opcode and random other bits
  function automatic logic [31:0] make_word(opc_t prim, opc_t ext);
    logic [31:0] w;
    w = $urandom;
    w[5:0]   = prim;
    w[16:11] = ext;
    return w;
  endfunction

  // Offer one transaction after a random gap and wait until it is taken
  task automatic send_item(logic [1:0] o, logic [31:0] w, logic [3:0] idx);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    op         <= o;
    instr_word <= w;
    read_index <= idx;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (o)
      OP_COUNT: n_count++;
      OP_CLEAR: n_clear++;
      OP_READ:  n_read++;
      default:  n_none++;
    endcase
  endtask

  task automatic count_word(logic [31:0] w);
    send_item(OP_COUNT, w, 4'($urandom_range(0, 15)));
  endtask

  // Receiver: random stalls, plus one long hold when asked
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_stall <= 1'b0;
          @(negedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int          r;
    logic [1:0]  o;
    logic [31:0] w;
    logic [3:0]  idx;
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = OP_COUNT;
    instr_word = '0;
    read_index = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    n_count = 0; n_clear = 0; n_read = 0; n_none = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset value, field extremes, every class, special reads and ops
    send_item(OP_READ, 32'h0, 4'd0);
    count_word(32'h0000_0000);
    count_word(32'hFFFF_FFFF);
    count_word(32'hFFFF_FFFA);            // R-type, unlisted extended opcode
    count_word(32'hFFFF_FFC0);            // J-type
    count_word(make_word(OPC_RTYPE, 6'h31));
    count_word(make_word(OPC_RTYPE, 6'h39));
    count_word(make_word(OPC_RTYPE, 6'h07));
    count_word(make_word(OPC_RTYPE, 6'h25));
    count_word(make_word(OPC_RTYPE, 6'h1E));
    count_word(make_word(OPC_RTYPE, 6'h30));
    count_word(make_word(OPC_RTYPE, 6'h3B));
    count_word(make_word(OPC_RTYPE, 6'h0D));
    count_word(make_word(6'h04, 6'($urandom)));
    count_word(make_word(6'h24, 6'($urandom)));
    count_word(make_word(6'h2F, 6'($urandom)));
    count_word(make_word(6'h35, 6'($urandom)));
    count_word(make_word(6'h36, 6'($urandom)));
    count_word(make_word(6'h3C, 6'($urandom)));
    count_word(make_word(6'h08, 6'($urandom)));
    send_item(OP_READ, $urandom, 4'd10);
    send_item(OP_READ, $urandom, 4'd15);  // index past the last class
    send_item(OP_NONE, $urandom, 4'($urandom_range(0, 15)));
    send_item(OP_CLEAR, $urandom, 4'($urandom_range(0, 15)));
    send_item(OP_READ, $urandom, 4'd6);

    // Random: mostly counted words, biased toward R-type and J-type opcodes
    for (int c = 0; c < CHUNKS; c++) begin
      calm = (c == 4) || (c == 7);
      if (c == 7) hold_req = 1'b1;
      for (int k = 0; k < CHUNK_LEN; k++) begin
        r   = $urandom_range(0, 99);
        w   = $urandom;
        idx = 4'($urandom_range(0, 15));
        if (r < 82) begin
          o = OP_COUNT;
          r = $urandom_range(0, 9);
          if (r < 4) w[5:0] = OPC_RTYPE;
          else if (r == 4) w[5:0] = OPC_JTYPE;
        end else if (r < 94) begin
          o = OP_READ;
          if ($urandom_range(0, 3) != 0) idx = 4'($urandom_range(0, 10));
        end else if (r < 97) begin
          o = OP_CLEAR;
        end else begin
          o = OP_NONE;
        end
        send_item(o, w, idx);
      end
    end
    calm = 1'b0;

    // Drain and settle
    @(negedge clk);
    in_valid <= 1'b0;
    wait (awaited == 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d counted words, %0d reads, %0d clears, %0d unused ops; %0d results checked",
             n_count, n_read, n_clear, n_none, compared);
    $display("Included all eleven classes, out-of-range reads and a long output hold");
    if (mismatches == 0 && awaited == 0) begin
      $display("tb_instruction_mix_counter_core passed");
    end else begin
      $display("tb_instruction_mix_counter_core failed");
    end
    $finish;
  end

endmodule
